@@ rtl/core/aki_pkg.sv @@
// Shared types, codes and the character-to-matrix key table for the keystroke injector.
// No dependencies; used by aki_ctrl, aki_dp and ascii_keystroke_injector.
`default_nettype none

package aki_pkg;

  localparam int unsigned OpW   = 2;
  localparam int unsigned EvW   = 2;
  localparam int unsigned CfgW  = 8;
  localparam int unsigned CharW = 8;
  localparam int unsigned RegIdxW = 2;

  localparam logic [OpW-1:0] OP_START = 2'd0;
  localparam logic [OpW-1:0] OP_PUSH  = 2'd1;
  localparam logic [OpW-1:0] OP_TICK  = 2'd2;

  localparam logic [EvW-1:0] EV_NONE    = 2'd0;
  localparam logic [EvW-1:0] EV_PRESS   = 2'd1;
  localparam logic [EvW-1:0] EV_RELEASE = 2'd2;

  localparam logic [RegIdxW-1:0] REG_HOLD  = 2'd0;
  localparam logic [RegIdxW-1:0] REG_GAP   = 2'd1;
  localparam logic [RegIdxW-1:0] REG_START = 2'd2;

  localparam logic [CfgW-1:0] HOLD_RST  = 8'd2;
  localparam logic [CfgW-1:0] GAP_RST   = 8'd1;
  localparam logic [CfgW-1:0] START_RST = 8'd3;

  typedef struct packed {
    logic capture;
    logic start;
    logic push;
    logic dec;
    logic rd;
    logic skip;
    logic key_act;
    logic emit;
  } aki_cmd_t;

  typedef struct packed {
    logic [OpW-1:0] op;
    logic           pending;
    logic           next_pending;
    logic           timer_zero;
    logic           entry_valid;
    logic           out_free;
  } aki_sts_t;

  // entry: valid, shift, row[2:0], col[2:0]
  function automatic logic [7:0] pk(input logic [2:0] row, input logic [2:0] col);
    return {2'b10, row, col};
  endfunction

  function automatic logic [7:0] sk(input logic [2:0] row, input logic [2:0] col);
    return {2'b11, row, col};
  endfunction

  function automatic logic [7:0] key_lookup(input logic [CharW-1:0] c);
    logic [7:0] e;
    e = 8'h00;
    if (!c[7]) begin
      unique case (c[6:0])
        7'h0A: e = pk(3'd0, 3'd1);
        7'h08: e = pk(3'd0, 3'd0);
        7'h20: e = pk(3'd7, 3'd4);
        7'h30: e = pk(3'd4, 3'd3);
        7'h31: e = pk(3'd7, 3'd0);
        7'h32: e = pk(3'd7, 3'd3);
        7'h33: e = pk(3'd1, 3'd0);
        7'h34: e = pk(3'd1, 3'd3);
        7'h35: e = pk(3'd2, 3'd0);
        7'h36: e = pk(3'd2, 3'd3);
        7'h37: e = pk(3'd3, 3'd0);
        7'h38: e = pk(3'd3, 3'd3);
        7'h39: e = pk(3'd4, 3'd0);
        7'h61, 7'h41: e = pk(3'd1, 3'd2);
        7'h62, 7'h42: e = pk(3'd3, 3'd4);
        7'h63, 7'h43: e = pk(3'd2, 3'd4);
        7'h64, 7'h44: e = pk(3'd2, 3'd2);
        7'h65, 7'h45: e = pk(3'd1, 3'd6);
        7'h66, 7'h46: e = pk(3'd2, 3'd5);
        7'h67, 7'h47: e = pk(3'd3, 3'd2);
        7'h68, 7'h48: e = pk(3'd3, 3'd5);
        7'h69, 7'h49: e = pk(3'd4, 3'd1);
        7'h6A, 7'h4A: e = pk(3'd4, 3'd2);
        7'h6B, 7'h4B: e = pk(3'd4, 3'd5);
        7'h6C, 7'h4C: e = pk(3'd5, 3'd2);
        7'h6D, 7'h4D: e = pk(3'd4, 3'd4);
        7'h6E, 7'h4E: e = pk(3'd4, 3'd7);
        7'h6F, 7'h4F: e = pk(3'd4, 3'd6);
        7'h70, 7'h50: e = pk(3'd5, 3'd1);
        7'h71, 7'h51: e = pk(3'd7, 3'd6);
        7'h72, 7'h52: e = pk(3'd2, 3'd1);
        7'h73, 7'h53: e = pk(3'd1, 3'd5);
        7'h74, 7'h54: e = pk(3'd2, 3'd6);
        7'h75, 7'h55: e = pk(3'd3, 3'd6);
        7'h76, 7'h56: e = pk(3'd3, 3'd7);
        7'h77, 7'h57: e = pk(3'd1, 3'd1);
        7'h78, 7'h58: e = pk(3'd2, 3'd7);
        7'h79, 7'h59: e = pk(3'd3, 3'd1);
        7'h7A, 7'h5A: e = pk(3'd1, 3'd4);
        7'h2B: e = pk(3'd5, 3'd0);
        7'h2D: e = pk(3'd5, 3'd3);
        7'h40: e = pk(3'd5, 3'd6);
        7'h2A: e = pk(3'd6, 3'd1);
        7'h3A: e = pk(3'd5, 3'd5);
        7'h3B: e = pk(3'd6, 3'd2);
        7'h3D: e = pk(3'd6, 3'd5);
        7'h2C: e = pk(3'd5, 3'd7);
        7'h2E: e = pk(3'd5, 3'd4);
        7'h2F: e = pk(3'd6, 3'd7);
        7'h21: e = sk(3'd7, 3'd0);
        7'h22: e = sk(3'd7, 3'd3);
        7'h23: e = sk(3'd1, 3'd0);
        7'h24: e = sk(3'd1, 3'd3);
        7'h25: e = sk(3'd2, 3'd0);
        7'h26: e = sk(3'd2, 3'd3);
        7'h27: e = sk(3'd3, 3'd0);
        7'h28: e = sk(3'd3, 3'd3);
        7'h29: e = sk(3'd4, 3'd0);
        7'h5B: e = sk(3'd5, 3'd5);
        7'h5D: e = sk(3'd6, 3'd2);
        7'h3C: e = sk(3'd5, 3'd7);
        7'h3E: e = sk(3'd5, 3'd4);
        7'h3F: e = sk(3'd6, 3'd7);
        default: e = 8'h00;
      endcase
    end
    return e;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/aki_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the text buffer of the keystroke injector.
`default_nettype none

module aki_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/core/aki_ctrl.sv @@
// Sequencer of the keystroke injector: decode, buffer read and skip loop, result hand-off.
// Depends on aki_pkg for the command and status structs and the opcodes.
`default_nettype none

module aki_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire aki_pkg::aki_sts_t sts_i,
  output aki_pkg::aki_cmd_t      cmd_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECODE = 2'd1;
  localparam logic [1:0] S_LOOK   = 2'd2;
  localparam logic [1:0] S_EMIT   = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_EMIT;
        priority if (sts_i.op == aki_pkg::OP_START) begin
          cmd_o.start = 1'b1;
        end else if (sts_i.op == aki_pkg::OP_PUSH) begin
          cmd_o.push = 1'b1;
        end else if (sts_i.op == aki_pkg::OP_TICK && sts_i.pending) begin
          if (!sts_i.timer_zero) begin
            cmd_o.dec = 1'b1;
          end else begin
            cmd_o.rd = 1'b1;
            state_d  = S_LOOK;
          end
        end else begin
          state_d = S_EMIT;
        end
      end
      S_LOOK: begin
        if (sts_i.entry_valid) begin
          cmd_o.key_act = 1'b1;
          state_d       = S_EMIT;
        end else begin
          cmd_o.skip = 1'b1;
          if (sts_i.next_pending) begin
            cmd_o.rd = 1'b1;
          end else begin
            state_d = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  a_look_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOOK) |-> sts_i.pending)
    else $error("buffer read with nothing left to play");

  a_capture_decodes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> (state_q == S_DECODE))
    else $error("accepted item not decoded");

endmodule

`default_nettype wire

@@ rtl/core/aki_dp.sv @@
// Datapath of the keystroke injector: settings, buffer pointers, frame timer, key state,
// text buffer and result register. Depends on aki_pkg and aki_ram.
`default_nettype none

module aki_dp #(
  parameter int unsigned BUFFER_DEPTH = 256
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [aki_pkg::RegIdxW-1:0] cfg_idx_i,
  input  wire logic [aki_pkg::CfgW-1:0]    cfg_data_i,
  input  wire logic [aki_pkg::OpW-1:0]     opcode_i,
  input  wire logic [aki_pkg::CharW-1:0]   char_code_i,
  input  wire logic                        out_stall_i,
  output logic                             out_valid_o,
  output logic      [aki_pkg::EvW-1:0]     key_event_o,
  output logic      [2:0]                  key_row_o,
  output logic      [2:0]                  key_col_o,
  output logic                             with_shift_o,
  output logic                             busy_res_o,
  output logic                             buffer_full_o,
  input  wire aki_pkg::aki_cmd_t           cmd_i,
  output aki_pkg::aki_sts_t                sts_o
);

  localparam int unsigned AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int unsigned CW = $clog2(BUFFER_DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(BUFFER_DEPTH);

  logic [aki_pkg::CfgW-1:0]  hold_q, gap_q, start_q;
  logic [CW-1:0]             fc_q, rp_q, rp_inc;
  logic [aki_pkg::CfgW-1:0]  timer_q;
  logic                      key_held_q;
  logic [aki_pkg::OpW-1:0]   op_q;
  logic [aki_pkg::CharW-1:0] ch_q;
  logic [aki_pkg::EvW-1:0]   ev_q;
  logic [2:0]                row_q, col_q;
  logic                      sh_q, full_q;
  logic                      out_valid_q;
  logic [aki_pkg::EvW-1:0]   o_ev_q;
  logic [2:0]                o_row_q, o_col_q;
  logic                      o_sh_q, o_busy_q, o_full_q;
  logic [aki_pkg::CharW-1:0] rd_data;
  logic [7:0]                entry;
  logic                      is_full, wr_en;
  logic [AW-1:0]             rd_addr;

  assign rp_inc  = rp_q + CW'(1);
  assign is_full = (fc_q >= DepthC);
  assign wr_en   = cmd_i.push && !is_full;
  assign rd_addr = cmd_i.skip ? rp_inc[AW-1:0] : rp_q[AW-1:0];
  assign entry   = aki_pkg::key_lookup(rd_data);

  aki_ram #(
    .WIDTH(aki_pkg::CharW),
    .DEPTH(BUFFER_DEPTH)
  ) u_text (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(fc_q[AW-1:0]),
    .wdata_i(ch_q),
    .re_i   (cmd_i.rd),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q  <= aki_pkg::HOLD_RST;
      gap_q   <= aki_pkg::GAP_RST;
      start_q <= aki_pkg::START_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        aki_pkg::REG_HOLD:  hold_q  <= cfg_data_i;
        aki_pkg::REG_GAP:   gap_q   <= cfg_data_i;
        aki_pkg::REG_START: start_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q       <= '0;
      rp_q       <= '0;
      timer_q    <= '0;
      key_held_q <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        fc_q       <= '0;
        rp_q       <= '0;
        key_held_q <= 1'b0;
        timer_q    <= start_q;
      end
      if (wr_en) begin
        fc_q <= fc_q + CW'(1);
      end
      if (cmd_i.dec) begin
        timer_q <= timer_q - 8'd1;
      end
      if (cmd_i.skip) begin
        rp_q <= rp_inc;
      end
      if (cmd_i.key_act) begin
        key_held_q <= !key_held_q;
        if (!key_held_q) begin
          timer_q <= hold_q;
        end else begin
          rp_q    <= rp_inc;
          timer_q <= (gap_q == 8'd0) ? 8'd1 : gap_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= opcode_i;
      ch_q   <= char_code_i;
      ev_q   <= aki_pkg::EV_NONE;
      row_q  <= 3'd0;
      col_q  <= 3'd0;
      sh_q   <= 1'b0;
      full_q <= 1'b0;
    end else begin
      if (cmd_i.push && is_full) begin
        full_q <= 1'b1;
      end
      if (cmd_i.key_act) begin
        ev_q  <= key_held_q ? aki_pkg::EV_RELEASE : aki_pkg::EV_PRESS;
        row_q <= entry[5:3];
        col_q <= entry[2:0];
        sh_q  <= entry[6];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      o_ev_q   <= ev_q;
      o_row_q  <= row_q;
      o_col_q  <= col_q;
      o_sh_q   <= sh_q;
      o_busy_q <= (rp_q < fc_q);
      o_full_q <= full_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign key_event_o   = o_ev_q;
  assign key_row_o     = o_row_q;
  assign key_col_o     = o_col_q;
  assign with_shift_o  = o_sh_q;
  assign busy_res_o    = o_busy_q;
  assign buffer_full_o = o_full_q;

  assign sts_o.op           = op_q;
  assign sts_o.pending      = (rp_q < fc_q);
  assign sts_o.next_pending = (rp_inc < fc_q);
  assign sts_o.timer_zero   = (timer_q == 8'd0);
  assign sts_o.entry_valid  = entry[7];
  assign sts_o.out_free     = !out_valid_q || !out_stall_i;

  a_rp_within_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rp_q <= fc_q)
    else $error("read position past fill count");

  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fc_q <= DepthC)
    else $error("fill count past buffer depth");

  a_key_held_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_held_q |-> (rp_q < fc_q))
    else $error("key held with no character under it");

  a_emit_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> out_valid_q && $stable(o_ev_q))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

@@ rtl/core/ascii_keystroke_injector.sv @@
// Top level of the keystroke injector: sequencer plus datapath.
// Depends on aki_pkg, aki_ctrl, aki_dp and aki_ram.
//
//   channel  direction  handshake                   payload
//   in       input      in_valid_i / in_stall_o     opcode_i, char_code_i
//   out      output     out_valid_o / out_stall_i   key_event_o .. buffer_full_o
//   cfg      input      cfg_we_i                    cfg_idx_i, cfg_data_i
//
// One item at a time: start, push and ticks that only count down or find nothing to play
// pass through capture, decode and emit; a tick that reads the buffer also loops in a
// lookup state over each byte read, set by the skip loop on the buffer RAM read port.
// A stalled waiting result holds the item in emit. in_stall_o is high while an item is
// in progress. The next item is taken while a result waits in the output register.
// Reset clears pointers, timer and key state and sets default settings, not the buffer.
`default_nettype none

module ascii_keystroke_injector #(
  parameter int unsigned BUFFER_DEPTH = 256
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [aki_pkg::RegIdxW-1:0] cfg_idx_i,
  input  wire logic [aki_pkg::CfgW-1:0]    cfg_data_i,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [aki_pkg::OpW-1:0]     opcode_i,
  input  wire logic [aki_pkg::CharW-1:0]   char_code_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic      [aki_pkg::EvW-1:0]     key_event_o,
  output logic      [2:0]                  key_row_o,
  output logic      [2:0]                  key_col_o,
  output logic                             with_shift_o,
  output logic                             busy_res_o,
  output logic                             buffer_full_o
);

  aki_pkg::aki_cmd_t cmd;
  aki_pkg::aki_sts_t sts;

  aki_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  aki_dp #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .opcode_i     (opcode_i),
    .char_code_i  (char_code_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .key_event_o  (key_event_o),
    .key_row_o    (key_row_o),
    .key_col_o    (key_col_o),
    .with_shift_o (with_shift_o),
    .busy_res_o   (busy_res_o),
    .buffer_full_o(buffer_full_o),
    .cmd_i        (cmd),
    .sts_o        (sts)
  );

endmodule

`default_nettype wire
